// ----- hdl/elfo_pkg.sv -----
`default_nettype none

package elfo_pkg;

    localparam int POS_W  = 8;
    localparam int SIZE_W = 7;
    localparam int ID_W   = 16;

    localparam logic [ID_W-1:0] ID_WRAP  = 16'hffff;
    localparam logic [ID_W-1:0] ID_FIRST = 16'h0001;

    // command codes
    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    // result status codes
    localparam logic [1:0] ST_PUT_OK    = 2'd0;
    localparam logic [1:0] ST_PUT_LARGE = 2'd1;
    localparam logic [1:0] ST_GET_OK    = 2'd2;
    localparam logic [1:0] ST_GET_EMPTY = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  ev_len;
        logic [7:0]  ev_cls;
        logic [31:0] checksum;
        logic [7:0]  data_byte;
        logic        last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   out_event_id;
        logic [SIZE_W-1:0] out_size;
        logic [7:0]        out_class;
        logic [31:0]       out_checksum;
        logic [7:0]        out_byte;
        logic              last_result;
    } t_out_item;

    // per-slot metadata word
    typedef struct packed {
        logic [7:0]        cls;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        logic [31:0]       sum;
    } t_meta;

    typedef enum logic [1:0] {
        S_IDLE,
        S_META,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/elfo_ram.sv -----
`default_nettype none

// simple dual port ram, registered read
module elfo_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- hdl/event_log_fifo_overwrite_oldest.sv -----
`default_nettype none

// channel   direction  handshake                        payload
// -------   ---------  -------------------------------  ----------------------
// in        input      i_in_valid / o_in_ready          i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_ready        o_out_data (t_out_item)
//
// put items: one transfer per cycle, the closing item of a run loads its result
//   into the output register in the same cycle
// get: S_META reads the slot metadata and first payload byte (registered ram read),
//   then S_EMIT gives one result per cycle while out_free holds, max(size,1) results
// no new item is taken while a get is being served or the output register is stuck
// synchronous active-low reset clears pointers, count and the open run, id to ID_FIRST;
//   the stores are not cleared, so there is no clearing pass

module event_log_fifo_overwrite_oldest #(
    parameter int QUEUE_DEPTH     = 8,
    parameter int MAX_EVENT_BYTES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  elfo_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output elfo_pkg::t_out_item o_out_data
);
    import elfo_pkg::*;

    localparam int SW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int PD  = QUEUE_DEPTH * MAX_EVENT_BYTES;
    localparam int AW  = $clog2(PD);
    localparam int AXW = AW + POS_W + 1;
    localparam int MW  = $bits(t_meta);

    // slot pointer advance with wrap at the queue depth
    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(QUEUE_DEPTH - 1)) ? '0 : s + SW'(1);
    endfunction

    // control state
    t_state          r_state, n_state;
    logic            r_out_valid;
    t_out_item       r_out_data;
    logic [SW-1:0]   r_head, r_tail;
    logic [CW-1:0]   r_count;
    logic [ID_W-1:0] r_next_id, n_next_id;
    logic [POS_W-1:0] r_pos;

    // metadata of the open put run
    logic [7:0]      r_pend_size, r_pend_cls;
    logic [31:0]     r_pend_sum;

    // byte index within the event being returned
    logic [SIZE_W-1:0] r_k;

    logic out_free, in_acc, put_acc, get_acc, first;
    logic [7:0]  cur_size, cur_cls, runlen;
    logic [31:0] cur_sum;
    logic        too_large, put_end, close_en, close_store, q_full;
    logic [POS_W:0] pos_inc, nb_src, close_nb;

    logic          pay_wr_en, pay_rd_en, meta_rd_en;
    logic [AXW-1:0] pay_wr_full, pay_rd_full;
    logic [SIZE_W-1:0] rd_k;
    logic [7:0]    pay_rd_data;
    t_meta         meta_wr, meta_rd;
    logic [MW-1:0] meta_rd_bits;

    logic      out_load, emit_last, emit_done, k_step;
    t_out_item out_next;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign put_acc    = in_acc && (i_in_data.cmd == CMD_PUT);
    assign get_acc    = in_acc && (i_in_data.cmd == CMD_GET);

    // the first item of a run supplies the metadata
    assign first    = (r_pos == '0);
    assign cur_size = first ? i_in_data.ev_len   : r_pend_size;
    assign cur_cls  = first ? i_in_data.ev_cls   : r_pend_cls;
    assign cur_sum  = first ? i_in_data.checksum : r_pend_sum;

    assign too_large = cur_size > 8'(MAX_EVENT_BYTES);
    assign pos_inc   = {1'b0, r_pos} + (POS_W + 1)'(1);
    assign runlen    = (cur_size == 8'd0) ? 8'd1 : cur_size;
    assign put_end   = (pos_inc >= {1'b0, runlen}) || i_in_data.last_byte;

    // a run closes at its final put item, or silently when a get cuts in
    assign close_en    = (put_acc && put_end) || (get_acc && !first);
    assign close_store = close_en && !too_large;
    assign q_full      = (r_count == CW'(QUEUE_DEPTH));

    // stored size is the number of bytes received, capped at the declared size
    assign nb_src   = put_acc ? pos_inc : {1'b0, r_pos};
    assign close_nb = (nb_src < {1'b0, cur_size}) ? nb_src : {1'b0, cur_size};

    always_comb begin
        n_next_id = r_next_id + ID_W'(1);
        if (n_next_id == ID_WRAP) begin
            n_next_id = ID_FIRST;
        end
    end

    // payload store: slot * max bytes + byte index
    assign pay_wr_en   = put_acc && !too_large && (r_pos < cur_size);
    assign pay_wr_full = AXW'(r_tail) * AXW'(MAX_EVENT_BYTES) + AXW'(r_pos);
    assign rd_k        = (r_state == S_EMIT) ? r_k + SIZE_W'(1) : '0;
    assign pay_rd_full = AXW'(r_head) * AXW'(MAX_EVENT_BYTES) + AXW'(rd_k);

    elfo_ram #(
        .WIDTH (8),
        .DEPTH (PD)
    ) u_payload (
        .i_clk     (i_clk),
        .i_wr_en   (pay_wr_en),
        .i_wr_addr (pay_wr_full[AW-1:0]),
        .i_wr_data (i_in_data.data_byte),
        .i_rd_en   (pay_rd_en),
        .i_rd_addr (pay_rd_full[AW-1:0]),
        .o_rd_data (pay_rd_data)
    );

    always_comb begin
        meta_wr.cls  = cur_cls;
        meta_wr.id   = r_next_id;
        meta_wr.size = close_nb[SIZE_W-1:0];
        meta_wr.sum  = cur_sum;
    end

    elfo_ram #(
        .WIDTH (MW),
        .DEPTH (QUEUE_DEPTH)
    ) u_meta (
        .i_clk     (i_clk),
        .i_wr_en   (close_store),
        .i_wr_addr (r_tail),
        .i_wr_data (meta_wr),
        .i_rd_en   (meta_rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (meta_rd_bits)
    );

    assign meta_rd   = t_meta'(meta_rd_bits);
    assign emit_last = (meta_rd.size == '0)
                    || ({1'b0, r_k} + 8'd1 == {1'b0, meta_rd.size});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (get_acc) begin
                    n_state = S_META;
                end
            end
            S_META: begin
                if (r_count != '0) begin
                    n_state = S_EMIT;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free && emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // per-state outputs: ram reads and output register load
    always_comb begin
        out_load   = 1'b0;
        out_next   = '0;
        meta_rd_en = 1'b0;
        pay_rd_en  = 1'b0;
        emit_done  = 1'b0;
        k_step     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (put_acc && put_end) begin
                    out_load             = 1'b1;
                    out_next.last_result = 1'b1;
                    if (too_large) begin
                        out_next.status = ST_PUT_LARGE;
                    end else begin
                        out_next.status       = ST_PUT_OK;
                        out_next.out_event_id = r_next_id;
                        out_next.out_size     = close_nb[SIZE_W-1:0];
                        out_next.out_class    = cur_cls;
                        out_next.out_checksum = cur_sum;
                    end
                end
            end
            S_META: begin
                if (r_count == '0) begin
                    if (out_free) begin
                        out_load             = 1'b1;
                        out_next.status      = ST_GET_EMPTY;
                        out_next.last_result = 1'b1;
                    end
                end else begin
                    meta_rd_en = 1'b1;
                    pay_rd_en  = 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load              = 1'b1;
                    out_next.status       = ST_GET_OK;
                    out_next.out_event_id = meta_rd.id;
                    out_next.out_size     = meta_rd.size;
                    out_next.out_class    = meta_rd.cls;
                    out_next.out_checksum = meta_rd.sum;
                    out_next.out_byte     = (meta_rd.size == '0) ? 8'd0 : pay_rd_data;
                    out_next.last_result  = emit_last;
                    if (emit_last) begin
                        emit_done = 1'b1;
                    end else begin
                        pay_rd_en = 1'b1;
                        k_step    = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_next_id   <= ID_FIRST;
            r_pos       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);
            // overwrite oldest: when full the head moves past the reused slot
            if (close_store) begin
                r_tail    <= slot_inc(r_tail);
                r_next_id <= n_next_id;
                if (q_full) begin
                    r_head <= slot_inc(r_tail);
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            // close and get completion never fall in the same cycle
            if (emit_done) begin
                r_head  <= slot_inc(r_head);
                r_count <= r_count - CW'(1);
            end
            if (put_acc) begin
                r_pos <= put_end ? '0 : pos_inc[POS_W-1:0];
            end else if (get_acc) begin
                r_pos <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= out_next;
        end
        if (put_acc && first) begin
            r_pend_size <= i_in_data.ev_len;
            r_pend_cls  <= i_in_data.ev_cls;
            r_pend_sum  <= i_in_data.checksum;
        end
        if (r_state == S_META) begin
            r_k <= '0;
        end else if (k_step) begin
            r_k <= r_k + SIZE_W'(1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> (r_head == r_tail))
        else $error("full queue with head and tail apart");

    a_get_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_done |=> (r_state == S_IDLE) && (r_count == $past(r_count) - CW'(1)))
        else $error("get completion did not release the entry");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !close_store && !pay_wr_en)
        else $error("store written while a get is served");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_event_log_fifo_overwrite_oldest.sv -----
`timescale 1ns / 100ps

module tb_event_log_fifo_overwrite_oldest;
    import elfo_pkg::*;

    // block geometry, matched to the instance below
    localparam int QD = 8;
    localparam int MB = 32;

    // how a put run is closed by the stimulus
    localparam int END_NATURAL = 0;   // full length, last_byte random on the final item
    localparam int END_MARKED  = 1;   // cut short with last_byte
    localparam int END_OPEN    = 2;   // left open, a get closes it

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 172;

    // shadow of the event queue plus the queue of results still owed
    class event_log_checker;
        logic [7:0]  ev_bytes [QD][MB];
        logic [7:0]  ev_class [QD];
        logic [15:0] ev_id    [QD];
        int          ev_size  [QD];
        logic [31:0] ev_csum  [QD];
        int          head_slot, tail_slot, fill;
        logic [15:0] next_id;
        int          run_pos;
        logic [7:0]  run_size, run_class;
        logic [31:0] run_csum;
        t_out_item   results_due[$];
        int errors, n_checked, n_put_ok, n_large, n_get, n_empty;
        int n_overwrite, n_short, n_wrap;

        function new();
            head_slot = 0;
            tail_slot = 0;
            fill      = 0;
            next_id   = ID_FIRST;
            run_pos   = 0;
            run_size  = '0;
            run_class = '0;
            run_csum  = '0;
        endfunction

        function t_out_item shape_result(logic [1:0] st, logic [15:0] id, int sz,
                                         logic [7:0] cls, logic [31:0] csum,
                                         logic [7:0] b, bit is_last);
            t_out_item r;
            r.status       = st;
            r.out_event_id = id;
            r.out_size     = sz[SIZE_W-1:0];
            r.out_class    = cls;
            r.out_checksum = csum;
            r.out_byte     = b;
            r.last_result  = is_last;
            return r;
        endfunction

        // closes the open run with nb bytes, returns the slot or -1 when dropped
        function int commit_run(int nb);
            int slot;
            run_pos = 0;
            if (run_size > MB) return -1;
            slot = tail_slot;
            if (fill >= QD) begin
                head_slot = (slot + 1) % QD;
                n_overwrite++;
            end else begin
                fill++;
            end
            ev_class[slot] = run_class;
            ev_id[slot]    = next_id;
            ev_size[slot]  = nb;
            ev_csum[slot]  = run_csum;
            tail_slot      = (slot + 1) % QD;
            next_id        = next_id + 16'd1;
            if (next_id == ID_WRAP) begin
                next_id = ID_FIRST;
                n_wrap++;
            end
            return slot;
        endfunction

        function void take_item(t_in_item it);
            int slot, run_len, nb, sz, n;
            if (it.cmd == CMD_PUT) begin
                if (run_pos == 0) begin
                    run_size  = it.ev_len;
                    run_class = it.ev_cls;
                    run_csum  = it.checksum;
                end
                if (run_size <= MB && run_pos < run_size)
                    ev_bytes[tail_slot][run_pos] = it.data_byte;
                run_pos++;
                run_len = (run_size == 0) ? 1 : run_size;
                if (run_pos < run_len && !it.last_byte) return;
                if (run_pos < run_len) n_short++;
                nb   = (run_pos < run_size) ? run_pos : run_size;
                slot = commit_run(nb);
                if (slot < 0) begin
                    results_due.push_back(shape_result(ST_PUT_LARGE, '0, 0, '0, '0, '0, 1'b1));
                    n_large++;
                end else begin
                    results_due.push_back(shape_result(ST_PUT_OK, ev_id[slot], ev_size[slot],
                                                       ev_class[slot], ev_csum[slot], '0, 1'b1));
                    n_put_ok++;
                end
                return;
            end
            // a get first closes any open run, silently
            if (run_pos != 0) begin
                n_short++;
                void'(commit_run((run_pos < run_size) ? run_pos : run_size));
            end
            if (fill == 0) begin
                results_due.push_back(shape_result(ST_GET_EMPTY, '0, 0, '0, '0, '0, 1'b1));
                n_empty++;
                return;
            end
            slot = head_slot;
            sz   = ev_size[slot];
            n    = (sz == 0) ? 1 : sz;
            for (int k = 0; k < n; k++)
                results_due.push_back(shape_result(ST_GET_OK, ev_id[slot], sz, ev_class[slot],
                                                   ev_csum[slot],
                                                   (k < sz) ? ev_bytes[slot][k] : 8'd0,
                                                   k == n - 1));
            head_slot = (slot + 1) % QD;
            fill--;
            n_get++;
        endfunction

        function void compare_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, fname, want_v, got_v);
            end
        endfunction

        function void match_result(t_out_item got);
            t_out_item want;
            n_checked++;
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = results_due.pop_front();
            compare_field("status",       32'(want.status),       32'(got.status));
            compare_field("out_event_id", 32'(want.out_event_id), 32'(got.out_event_id));
            compare_field("out_size",     32'(want.out_size),     32'(got.out_size));
            compare_field("out_class",    32'(want.out_class),    32'(got.out_class));
            compare_field("out_checksum", want.out_checksum,      got.out_checksum);
            compare_field("out_byte",     32'(want.out_byte),     32'(got.out_byte));
            compare_field("last_result",  32'(want.last_result),  32'(got.last_result));
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    event_log_checker sb = new();

    // traffic shaping knobs, set by the main sequence
    bit tx_bursty;
    bit hold_req;
    int burst_left;
    int n_items;
    int idle_cycles;

    event_log_fifo_overwrite_oldest #(
        .QUEUE_DEPTH     (QD),
        .MAX_EVENT_BYTES (MB)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // every field random, callers override what matters
    function automatic t_in_item rand_item();
        t_in_item it;
        it.cmd       = 1'($urandom_range(0, 1));
        it.ev_len    = 8'($urandom);
        it.ev_cls    = 8'($urandom);
        it.checksum  = $urandom;
        it.data_byte = 8'($urandom);
        it.last_byte = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // offer one item, hold it until the transfer, then maybe open a gap
    task automatic send(input t_in_item it);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_item(it);
        n_items++;
        if (tx_bursty) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 8);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 10);
            end else begin
                burst_left--;
            end
        end
    endtask

    // one put run: metadata on the first item, junk in the metadata of the rest
    task automatic put_event(input logic [7:0] sz, input logic [7:0] cls,
                             input logic [31:0] csum, input int n_send, input int end_kind);
        t_in_item it;
        for (int k = 0; k < n_send; k++) begin
            it     = rand_item();
            it.cmd = CMD_PUT;
            if (k == 0) begin
                it.ev_len   = sz;
                it.ev_cls   = cls;
                it.checksum = csum;
            end
            if (k < n_send - 1 || end_kind == END_OPEN)
                it.last_byte = 1'b0;
            else if (end_kind == END_MARKED)
                it.last_byte = 1'b1;
            send(it);
        end
    endtask

    task automatic get_event();
        t_in_item it;
        it     = rand_item();
        it.cmd = CMD_GET;
        send(it);
    endtask

    // receiver: long hold on request, else a changing stall pattern
    initial begin
        int pat_left;
        int ready_pct;
        pat_left  = 0;
        ready_pct = 100;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (pat_left == 0) begin
                    pat_left = $urandom_range(16, 64);
                    case ($urandom_range(0, 2))
                        0: begin
                            ready_pct = 100;
                        end
                        1: begin
                            ready_pct = 75;
                        end
                        default: begin
                            ready_pct = 40;
                        end
                    endcase
                end
                pat_left--;
                i_out_ready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    // result checking and the no-progress watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.match_result(o_out_data);
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                             $time, idle_cycles, sb.results_due.size());
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        int r, sz, start;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        tx_bursty   = 1'b1;
        hold_req    = 1'b0;
        burst_left  = 3;
        n_items     = 0;
        idle_cycles = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty get, zero-size event, extremes of class and checksum
        get_event();
        put_event(8'd0, 8'h00, 32'h0000_0000, 1, END_NATURAL);
        put_event(8'd1, 8'hff, 32'hffff_ffff, 1, END_NATURAL);
        get_event();
        get_event();
        get_event();
        // just over the size limit, and the largest size, both dropped
        put_event(8'd33, 8'h5a, 32'h1234_5678, 2, END_MARKED);
        put_event(8'd255, 8'ha5, 32'hdead_beef, 1, END_MARKED);
        // run cut short by last_byte: stored with two bytes
        put_event(8'd4, 8'h11, 32'h8000_0001, 2, END_MARKED);
        // runs closed by a get: one kept short, one oversized and dropped
        put_event(8'd3, 8'h22, 32'h7fff_fffe, 2, END_OPEN);
        get_event();
        put_event(8'd40, 8'h33, 32'h0f0f_0f0f, 1, END_OPEN);
        get_event();
        // nine events into an eight-entry queue, the oldest is overwritten
        repeat (9) put_event(8'd0, 8'($urandom), $urandom, 1, END_NATURAL);
        get_event();

        // receiver holds off while the sender keeps offering, input backs up
        tx_bursty = 1'b0;
        hold_req  = 1'b1;
        repeat (8) put_event(8'd0, 8'($urandom), $urandom, 1, END_NATURAL);
        get_event();
        get_event();
        repeat (4) put_event(8'd3, 8'($urandom), $urandom, 3, END_NATURAL);
        tx_bursty = 1'b1;

        // random mix, mostly well-formed runs with random content
        start = n_items;
        while (n_items - start < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                get_event();
            end else if (r < 45) begin
                sz = $urandom_range(33, 255);
                if (sz <= 48 && $urandom_range(0, 3) == 0)
                    put_event(8'(sz), 8'($urandom), $urandom, sz, END_NATURAL);
                else
                    put_event(8'(sz), 8'($urandom), $urandom, $urandom_range(1, 4),
                              END_MARKED);
            end else if (r < 52) begin
                sz = $urandom_range(2, 32);
                put_event(8'(sz), 8'($urandom), $urandom, $urandom_range(1, sz - 1),
                          END_OPEN);
                get_event();
            end else if (r < 60) begin
                sz = $urandom_range(2, 32);
                put_event(8'(sz), 8'($urandom), $urandom, $urandom_range(1, sz - 1),
                          END_MARKED);
            end else begin
                sz = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 32)
                                                 : $urandom_range(0, 8);
                put_event(8'(sz), 8'($urandom), $urandom, (sz == 0) ? 1 : sz, END_NATURAL);
            end
        end
        i_in_valid <= 1'b0;

        // drain, then leave room for anything still in flight
        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("%0d input transfers, %0d results checked: %0d events stored, %0d too large,",
                 n_items, sb.n_checked, sb.n_put_ok, sb.n_large);
        $display("%0d gets with data, %0d empty gets, %0d oldest entries overwritten, %0d runs closed early",
                 sb.n_get, sb.n_empty, sb.n_overwrite, sb.n_short);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/elfo_pkg.sv
hdl/elfo_ram.sv
hdl/event_log_fifo_overwrite_oldest.sv
bench/tb_event_log_fifo_overwrite_oldest.sv
